// ===== rtl/core/mavg_pkg.sv =====
// Package with shared types, register indexes and defaults of the averaging filter.
`default_nettype none
package mavg_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WIN_W     = 7;
  localparam int ALPHA_W   = 17;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_MUL1,
    B_MUL2,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic               start;
    logic               mode;
    logic [WIN_W-1:0]   win;
    logic [ALPHA_W-1:0] alpha;
  } item_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/mavg_front.sv =====
// Front end: accepts items, attaches the clamped settings and queues them for the back end.
`default_nettype none
module mavg_front #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 push,
  output logic                                full,
  input  wire  signed [SAMPLE_BITS-1:0]       in_sample,
  input  wire                                 in_record_start,
  input  wire                                 cfg_mode,
  input  wire         [mavg_pkg::WIN_W-1:0]   cfg_window,
  input  wire         [mavg_pkg::ALPHA_W-1:0] cfg_alpha,
  output logic                                q_valid,
  input  wire                                 q_pop,
  output logic signed [SAMPLE_BITS-1:0]       q_sample,
  output mavg_pkg::item_ctl_t                 q_ctl
);

  logic signed [SAMPLE_BITS-1:0] smp_r [2];
  mavg_pkg::item_ctl_t           ctl_r [2];
  logic                          wr_ptr_r, wr_ptr_nxt;
  logic                          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                    count_r, count_nxt;
  logic                          accept;
  mavg_pkg::item_ctl_t           ctl_in;

  always_comb begin
    ctl_in.start = in_record_start;
    ctl_in.mode  = cfg_mode;
    if (cfg_window == '0) begin
      ctl_in.win = mavg_pkg::WIN_W'(1);
    end else if (32'(cfg_window) > MAX_WINDOW) begin
      ctl_in.win = mavg_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      ctl_in.win = cfg_window;
    end
    ctl_in.alpha = (cfg_alpha > mavg_pkg::ALPHA_ONE) ? mavg_pkg::ALPHA_ONE : cfg_alpha;
  end

  assign full     = (count_r == 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign accept   = push && !full;
  assign q_sample = smp_r[rd_ptr_r];
  assign q_ctl    = ctl_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(accept) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r[wr_ptr_r] <= in_sample;
      ctl_r[wr_ptr_r] <= ctl_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mavg_div.sv =====
// Restoring serial divider producing one quotient bit per cycle.
`default_nettype none
module mavg_div #(
  parameter int NW = 23,
  parameter int DW = 7
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  wire  [NW-1:0] dividend,
  input  wire  [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW:0]    rem_r, rem_nxt;
  logic [NW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DW:0]    rem_sh;
  logic           ge;

  always_comb begin
    rem_sh   = {rem_r[DW-1:0], quo_r[NW-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/mavg_back.sv =====
// Back end: history ring, window sum, averaging divide, smoother and result register.
`default_nettype none
module mavg_back #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           q_valid,
  output logic                          q_pop,
  input  wire  signed [SAMPLE_BITS-1:0] q_sample,
  input  mavg_pkg::item_ctl_t           q_ctl,
  output logic                          empty,
  input  wire                           pop,
  output logic signed [SAMPLE_BITS-1:0] out_filtered
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int FW    = $clog2(MAX_WINDOW + 1);
  localparam int WW    = mavg_pkg::WIN_W;
  localparam int CW    = (FW > WW) ? FW : WW;
  localparam int SUM_W = SAMPLE_BITS + WW;
  localparam int PW    = SAMPLE_BITS + mavg_pkg::ALPHA_W + 1;
  localparam int ACC_W = PW + 1;
  localparam logic signed [ACC_W-1:0] SMAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SMAX) begin
      c = SMAX;
    end else if (v < SMIN) begin
      c = SMIN;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  mavg_pkg::back_state_t st_r, st_nxt;
  logic [AW-1:0]     wp_r, wp_nxt, wp_use, ridx_r, ridx_nxt;
  logic [FW-1:0]     fill_r, fill_nxt, fill_base;
  logic [WW-1:0]     cnt_r, cnt_nxt, n_r, n_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  mavg_pkg::item_ctl_t           ctl_r, ctl_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SAMPLE_BITS-1:0]        y_r, y_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic              rd_en, div_start, div_done, out_load;
  logic [CW-1:0]     win_ext;
  logic [SUM_W-1:0]  sum_mag, quo;
  logic              sum_neg_r;
  logic signed [SUM_W-1:0] quo_s;
  logic signed [ACC_W-1:0] quo_ext, prod_ext, mul2, acc, acc_sh;
  logic signed [mavg_pkg::ALPHA_W:0] inv_s, a_s;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mavg_pkg::B_IDLE: begin
        if (q_valid) begin
          st_nxt = q_ctl.mode ? mavg_pkg::B_MUL1 : mavg_pkg::B_SUM;
        end
      end
      mavg_pkg::B_SUM: begin
        if (cnt_r == n_r && !rd_vld_r) begin
          st_nxt = mavg_pkg::B_DIV;
        end
      end
      mavg_pkg::B_DIV: begin
        if (div_done) begin
          st_nxt = mavg_pkg::B_OUT;
        end
      end
      mavg_pkg::B_MUL1: begin
        st_nxt = ctl_r.start ? mavg_pkg::B_OUT : mavg_pkg::B_MUL2;
      end
      mavg_pkg::B_MUL2: begin
        st_nxt = mavg_pkg::B_OUT;
      end
      mavg_pkg::B_OUT: begin
        if (!out_valid_r || pop) begin
          st_nxt = mavg_pkg::B_IDLE;
        end
      end
      default: st_nxt = mavg_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (st_r == mavg_pkg::B_IDLE) && q_valid;
    rd_en     = (st_r == mavg_pkg::B_SUM) && (cnt_r < n_r);
    div_start = (st_r == mavg_pkg::B_SUM) && (cnt_r == n_r) && !rd_vld_r;
    out_load  = (st_r == mavg_pkg::B_OUT) && (!out_valid_r || pop);
  end

  always_comb begin
    wp_use    = q_ctl.start ? '0 : wp_r;
    fill_base = q_ctl.start ? '0 : fill_r;
    win_ext   = CW'(q_ctl.win);
    sum_mag   = sum_r[SUM_W-1] ? (SUM_W'(0) - sum_r) : sum_r;
    quo_s     = sum_neg_r ? (SUM_W'(0) - $signed(quo)) : $signed(quo);
    quo_ext   = quo_s;
    inv_s     = $signed({1'b0, mavg_pkg::ALPHA_ONE - ctl_r.alpha});
    a_s       = $signed({1'b0, ctl_r.alpha});
    prod_nxt  = inv_s * prev_r;
    prod_ext  = prod_r;
    mul2      = a_s * x_r;
    acc       = prod_ext + mul2;
    acc_sh    = acc >>> mavg_pkg::FRAC_BITS;
  end

  always_comb begin
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    ridx_nxt      = ridx_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    rd_vld_nxt    = rd_en;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    ctl_nxt       = ctl_r;
    prev_nxt      = prev_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      wp_nxt   = (wp_use == AW'(MAX_WINDOW - 1)) ? '0 : wp_use + AW'(1);
      fill_nxt = (fill_base < FW'(MAX_WINDOW)) ? fill_base + FW'(1) : fill_base;
      ridx_nxt = wp_use;
      cnt_nxt  = '0;
      n_nxt    = (CW'(fill_nxt) < win_ext) ? WW'(fill_nxt) : q_ctl.win;
      sum_nxt  = '0;
      x_nxt    = q_sample;
      ctl_nxt  = q_ctl;
    end
    if (rd_en) begin
      cnt_nxt  = cnt_r + WW'(1);
      ridx_nxt = (ridx_r == '0) ? AW'(MAX_WINDOW - 1) : ridx_r - AW'(1);
    end
    if (rd_vld_r) begin
      sum_nxt = sum_r + SUM_W'(rd_data_r);
    end
    if (st_r == mavg_pkg::B_DIV && div_done) begin
      y_nxt = sat_sample(quo_ext);
    end
    if (st_r == mavg_pkg::B_MUL1 && ctl_r.start) begin
      y_nxt = x_r;
    end
    if (st_r == mavg_pkg::B_MUL2) begin
      y_nxt = sat_sample(acc_sh);
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = $signed(y_r);
      prev_nxt      = $signed(y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mavg_pkg::B_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      n_r         <= '0;
      rd_vld_r    <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      rd_vld_r    <= rd_vld_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r     <= ridx_nxt;
    sum_r      <= sum_nxt;
    x_r        <= x_nxt;
    ctl_r      <= ctl_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    if (div_start) begin
      sum_neg_r <= sum_r[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem[wp_use] <= q_sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[ridx_r];
    end
  end

  mavg_div #(
    .NW(SUM_W),
    .DW(WW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_mag),
    .divisor (ctl_r.win),
    .done    (div_done),
    .quotient(quo)
  );

  assign empty        = !out_valid_r;
  assign out_filtered = out_data_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_WINDOW))
    else $error("History fill count exceeds the ring depth.");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < MAX_WINDOW)
    else $error("Write pointer outside the ring.");

  a_sum_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mavg_pkg::B_SUM) |-> (cnt_r <= n_r && n_r != '0))
    else $error("Window sum read count out of range.");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == mavg_pkg::B_DIV))
    else $error("Divider finished outside the divide state.");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !pop) |-> !out_valid_r)
    else $error("Result register overwritten while still held.");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/moving_average_or_first_order_smoother.sv =====
// Top level of the moving average and first-order smoothing filter.
`default_nettype none
// One result item per input item. In moving average mode the window sum covers
// n samples, where n is the smaller of the window and the number of samples
// since the record start: the sum is read back from the single-port history
// ring one entry per cycle, then a serial divider works out the average.
// In smoothing mode an item passes through the two registered multiply steps;
// an item that starts a record skips the second and passes its sample through.
// A two-entry input queue and a result register let the input and result sides
// stall independently of the filter core.
module moving_average_or_first_order_smoother #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   push,
  output logic                                  full,
  input  wire  signed [SAMPLE_BITS-1:0]         in_sample,
  input  wire                                   in_record_start,
  output logic                                  empty,
  input  wire                                   pop,
  output logic signed [SAMPLE_BITS-1:0]         out_filtered,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire         [mavg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire         [mavg_pkg::CFG_W-1:0]     cfg_data
);

  logic                           mode_r, mode_nxt;
  logic [mavg_pkg::WIN_W-1:0]     window_r, window_nxt;
  logic [mavg_pkg::ALPHA_W-1:0]   alpha_r, alpha_nxt;

  logic                           q_valid, q_pop;
  logic signed [SAMPLE_BITS-1:0]  q_sample;
  mavg_pkg::item_ctl_t            q_ctl;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    window_nxt = window_r;
    alpha_nxt  = alpha_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mavg_pkg::REG_MODE:   mode_nxt   = cfg_data[0];
        mavg_pkg::REG_WINDOW: window_nxt = cfg_data[mavg_pkg::WIN_W-1:0];
        mavg_pkg::REG_ALPHA:  alpha_nxt  = cfg_data[mavg_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      window_r <= mavg_pkg::WIN_W'(1);
      alpha_r  <= mavg_pkg::ALPHA_ONE;
    end else begin
      mode_r   <= mode_nxt;
      window_r <= window_nxt;
      alpha_r  <= alpha_nxt;
    end
  end

  mavg_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_sample      (in_sample),
    .in_record_start(in_record_start),
    .cfg_mode       (mode_r),
    .cfg_window     (window_r),
    .cfg_alpha      (alpha_r),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_sample       (q_sample),
    .q_ctl          (q_ctl)
  );

  mavg_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_sample    (q_sample),
    .q_ctl       (q_ctl),
    .empty       (empty),
    .pop         (pop),
    .out_filtered(out_filtered)
  );

endmodule
`default_nettype wire

// ===== tb/sv/moving_average_or_first_order_smoother_tb.sv =====
// Testbench for the moving average and first-order smoothing filter, checked against a predictor.
module moving_average_or_first_order_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = mavg_pkg::SAMPLE_BITS_DEF;
  localparam int MAXW = mavg_pkg::MAX_WINDOW_DEF;
  localparam int PTR_W = $clog2(MAXW);
  localparam int IDX_W = mavg_pkg::CFG_IDX_W;
  localparam int DAT_W = mavg_pkg::CFG_W;
  localparam int WW = mavg_pkg::WIN_W;
  localparam int AW = mavg_pkg::ALPHA_W;
  localparam longint SMAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int END_WAIT = 200;
  localparam int MAX_REPORTS = 100;

  class smoother_scoreboard;
    logic                 mode_q;
    logic [WW-1:0]        win_q;
    logic [AW-1:0]        alpha_q;
    logic signed [SW-1:0] ring [MAXW];
    logic [PTR_W-1:0]     wptr;
    logic [PTR_W:0]       fill;
    logic signed [SW-1:0] prev;
    logic signed [SW-1:0] filtered_q [$];
    int                   errors;

    function new();
      mode_q = 1'b0;
      win_q = 7'd1;
      alpha_q = mavg_pkg::ALPHA_ONE;
      foreach (ring[i]) ring[i] = '0;
      wptr = '0;
      fill = '0;
      prev = '0;
      errors = 0;
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
      case (idx)
        mavg_pkg::REG_MODE: mode_q = data[0];
        mavg_pkg::REG_WINDOW: win_q = data[WW-1:0];
        mavg_pkg::REG_ALPHA: alpha_q = data[AW-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [SW-1:0] x, logic st);
      longint w, n, sum, a, acc, yl;
      int idx, k;
      if (st) begin
        fill = '0;
        wptr = '0;
      end
      ring[wptr] = x;
      wptr = wptr + 1'b1;
      if (fill < MAXW) fill = fill + 1'b1;
      if (mode_q == 1'b0) begin
        if (win_q == 0) w = 1;
        else if (win_q > MAXW) w = MAXW;
        else w = longint'(win_q);
        n = (longint'(fill) < w) ? longint'(fill) : w;
        sum = 0;
        idx = int'(wptr);
        for (k = 0; k < n; k++) begin
          idx = (idx == 0) ? MAXW - 1 : idx - 1;
          sum += longint'(ring[idx]);
        end
        yl = sum / w;
      end else if (st) begin
        yl = longint'(x);
      end else begin
        a = (alpha_q > mavg_pkg::ALPHA_ONE) ? longint'(mavg_pkg::ALPHA_ONE)
                                            : longint'(alpha_q);
        acc = ((longint'(1) <<< mavg_pkg::FRAC_BITS) - a) * longint'(prev)
              + a * longint'(x);
        yl = acc >>> mavg_pkg::FRAC_BITS;
      end
      if (yl > SMAX) yl = SMAX;
      if (yl < SMIN) yl = SMIN;
      prev = yl[SW-1:0];
      filtered_q.push_back(prev);
    endfunction

    task report(string what);
      if (errors < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (filtered_q.size() == 0) begin
        report($sformatf("result %0d with no item waiting", got));
      end else begin
        want = filtered_q.pop_front();
        if (got !== want) report($sformatf("filtered got %0d want %0d", got, want));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic signed [SW-1:0] in_sample = '0;
  logic                 in_record_start = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [SW-1:0] out_filtered;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [DAT_W-1:0]     cfg_data = '0;

  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  smoother_scoreboard sb = new();

  moving_average_or_first_order_smoother u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_sample(in_sample),
    .in_record_start(in_record_start),
    .empty(empty),
    .pop(pop),
    .out_filtered(out_filtered),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (push && !full) begin
        sb.note_input(in_sample, in_record_start);
        moved = 1'b1;
      end
      if (pop && !empty) begin
        sb.check_result(out_filtered);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL moving_average_or_first_order_smoother");
    $finish;
  end

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_item(input logic signed [SW-1:0] smp, input logic st);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      in_sample <= SW'($urandom);
      in_record_start <= 1'($urandom);
      @(posedge clk);
    end
    push <= 1'b1;
    in_sample <= smp;
    in_record_start <= st;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_index <= IDX_W'($urandom);
    cfg_data <= DAT_W'($urandom);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SMAX[SW-1:0];
      1: return SMIN[SW-1:0];
      2: return SW'($signed($urandom_range(16)) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [WW-1:0] pick_window();
    case ($urandom_range(5))
      0: return '0;
      1: return 7'd1;
      2: return MAXW[WW-1:0];
      3: return WW'($urandom_range(127, MAXW + 1));
      default: return WW'($urandom_range(MAXW, 1));
    endcase
  endfunction

  function automatic logic [AW-1:0] pick_alpha();
    case ($urandom_range(4))
      0: return '0;
      1: return mavg_pkg::ALPHA_ONE;
      2: return AW'($urandom_range(131071, 65537));
      3: return 17'd1;
      default: return AW'($urandom_range(65535, 0));
    endcase
  endfunction

  task automatic run_segment(input int count);
    logic st;
    int i;
    set_reg(mavg_pkg::REG_MODE, {16'($urandom), 1'($urandom)});
    set_reg(mavg_pkg::REG_WINDOW, {10'($urandom), pick_window()});
    set_reg(mavg_pkg::REG_ALPHA, pick_alpha());
    for (i = 0; i < count; i++) begin
      st = (i == 0) ? 1'($urandom) : ($urandom_range(39) == 0);
      send_item(pick_sample(), st);
    end
  endtask

  initial begin
    int ph, seg;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, no record start yet: history before reset counts as zero.
    send_item(SMAX[SW-1:0], 1'b0);
    send_item(SMIN[SW-1:0], 1'b0);
    send_item('0, 1'b0);
    send_item(-16'sd1, 1'b0);
    set_reg(mavg_pkg::REG_WINDOW, '0);
    send_item(16'sd12345, 1'b1);
    send_item(SMIN[SW-1:0], 1'b0);
    set_reg(mavg_pkg::REG_WINDOW, DAT_W'(MAXW));
    send_item(SMAX[SW-1:0], 1'b1);
    repeat (3) send_item(SMAX[SW-1:0], 1'b0);
    repeat (2) send_item(SMIN[SW-1:0], 1'b0);
    set_reg(mavg_pkg::REG_WINDOW, 17'h1FF7F);
    send_item(SMIN[SW-1:0], 1'b0);
    send_item(SMAX[SW-1:0], 1'b0);
    // The window changes in the middle of a record.
    set_reg(mavg_pkg::REG_WINDOW, 17'd3);
    send_item(16'sd100, 1'b1);
    send_item(16'sd200, 1'b0);
    send_item(-16'sd300, 1'b0);
    set_reg(mavg_pkg::REG_WINDOW, 17'd5);
    send_item(16'sd1000, 1'b0);
    set_reg(mavg_pkg::REG_MODE, 17'h1FFFF);
    set_reg(mavg_pkg::REG_ALPHA, '0);
    send_item(SMIN[SW-1:0], 1'b0);
    send_item(SMAX[SW-1:0], 1'b0);
    set_reg(mavg_pkg::REG_ALPHA, mavg_pkg::ALPHA_ONE);
    send_item(SMIN[SW-1:0], 1'b0);
    set_reg(mavg_pkg::REG_ALPHA, 17'h1FFFF);
    send_item(SMAX[SW-1:0], 1'b0);
    set_reg(mavg_pkg::REG_ALPHA, 17'd32768);
    send_item(SMIN[SW-1:0], 1'b1);
    send_item(SMAX[SW-1:0], 1'b0);
    send_item(-16'sd1, 1'b0);
    set_reg(REG_UNUSED, DAT_W'($urandom));
    send_item(16'sd5, 1'b0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      for (seg = 0; seg < 3; seg++) run_segment(37);
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS moving_average_or_first_order_smoother");
    end else begin
      $display("FAIL moving_average_or_first_order_smoother");
    end
    $finish;
  end
endmodule
